// File: rtl/lrotf_pkg.sv
// Shared types, constants and tables for the lidar ring offset time filter.
package lrotf_pkg;

  localparam int MAX_RINGS_DEF    = 128;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int Q_DEPTH          = 4;
  // Holds every beat that can be in flight in the back end at the longest step count.
  localparam int OUT_DEPTH        = 32;

  localparam int PW = 24;  // coordinate width
  localparam int CW = 27;  // CORDIC datapath width
  localparam int YW = 16;  // yaw width, 1/64 degree

  localparam logic signed [CW-1:0] HALF_TURN_Q16 = CW'(11796480);
  localparam logic signed [16:0]   HALF_TURN_64  = 17'sd11520;
  localparam logic signed [16:0]   FULL_TURN_64  = 17'sd23040;
  localparam logic [17:0]          REV_US        = 18'd99723;

  // us = floor((d*3125 + 361) / 722), divide done as reciprocal multiply (exact for n < 2^27)
  localparam logic [11:0] DIST_MUL   = 12'd3125;
  localparam logic [26:0] DIST_ROUND = 27'd361;
  localparam logic [27:0] DIST_RECIP = 28'd190358662;
  localparam int          DIST_SHIFT = 37;

  typedef enum logic [1:0] {
    CFG_RING_COUNT = 2'd0,
    CFG_DECIMATION = 2'd1,
    CFG_BLIND_MM   = 2'd2,
    CFG_TIME_SCALE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 frame_start;
    logic                 given;
    logic                 phase_ok;
    logic                 in_use;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic [15:0]          strength;
    logic [7:0]           ring;
    logic signed [31:0]   raw_time;
  } item_t;

  typedef struct packed {
    item_t              item;
    logic signed [31:0] t_given;
    logic               far;
  } side_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
    logic [15:0]          strength;
    logic signed [31:0]   time_us;
  } res_t;

  // atan(2^-i) in 2^-16 degree, rounded
  function automatic logic signed [CW-1:0] atan_q16(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = CW'(2949120);
      1:  v = CW'(1740967);
      2:  v = CW'(919879);
      3:  v = CW'(466945);
      4:  v = CW'(234379);
      5:  v = CW'(117304);
      6:  v = CW'(58666);
      7:  v = CW'(29335);
      8:  v = CW'(14668);
      9:  v = CW'(7334);
      10: v = CW'(3667);
      11: v = CW'(1833);
      12: v = CW'(917);
      13: v = CW'(458);
      14: v = CW'(229);
      15: v = CW'(115);
      16: v = CW'(57);
      17: v = CW'(29);
      18: v = CW'(14);
      19: v = CW'(7);
      20: v = CW'(4);
      21: v = CW'(2);
      22: v = CW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/lrotf_fifo.sv
// Small register FIFO used for the classify queue and the result queue.
module lrotf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (do_pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    cnt_nxt = cnt_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

// File: rtl/lrotf_front.sv
// Front end: accepts points, tracks the frame index phase and classifies each point.
module lrotf_front #(
  parameter int MAX_RINGS = lrotf_pkg::MAX_RINGS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    frame_start,
  input  logic                    times_given,
  input  logic signed [23:0]      pos_x,
  input  logic signed [23:0]      pos_y,
  input  logic signed [23:0]      pos_z,
  input  logic [15:0]             strength,
  input  logic [7:0]              ring,
  input  logic signed [31:0]      raw_time,
  input  logic [7:0]              ring_count,
  input  logic [6:0]              decimation,
  input  logic                    q_full,
  output logic                    q_push,
  output lrotf_pkg::item_t        q_item
);

  logic [5:0] phase_r, phase_nxt;
  logic [5:0] ph;
  logic [6:0] dec, ph_inc;
  logic       acc, in_use, keep;

  always_comb begin
    acc    = push && !q_full;
    ph     = frame_start ? 6'd0 : phase_r;
    if (decimation == 7'd0)      dec = 7'd1;
    else if (decimation > 7'd64) dec = 7'd64;
    else                         dec = decimation;
    ph_inc = {1'b0, ph} + 7'd1;
    phase_nxt = phase_r;
    if (acc) phase_nxt = (ph_inc >= dec) ? 6'd0 : ph_inc[5:0];
    in_use = ({1'b0, ring} < {1'b0, ring_count}) && ({1'b0, ring} < 9'(MAX_RINGS));
    // frame start beats always travel on: they mark every ring unseen downstream
    keep   = frame_start || (in_use && (!times_given || ph == 6'd0));
    q_push = acc && keep;

    q_item.frame_start = frame_start;
    q_item.given       = times_given;
    q_item.phase_ok    = (ph == 6'd0);
    q_item.in_use      = in_use;
    q_item.pos_x       = pos_x;
    q_item.pos_y       = pos_y;
    q_item.pos_z       = pos_z;
    q_item.strength    = strength;
    q_item.ring        = ring;
    q_item.raw_time    = raw_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= '0;
    else        phase_r <= phase_nxt;
  end

endmodule

// File: rtl/lrotf_cordic.sv
// Pipelined vectoring CORDIC: one rotation per stage, yaw out in 1/64 degree.
module lrotf_cordic #(
  parameter int STEPS = lrotf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  lrotf_pkg::side_t             in_side,
  output logic                         out_valid,
  output lrotf_pkg::side_t             out_side,
  output logic signed [lrotf_pkg::YW-1:0] out_yaw
);

  localparam int CW = lrotf_pkg::CW;

  logic                 v_r    [STEPS+1];
  lrotf_pkg::side_t     side_r [STEPS+1];
  logic signed [CW-1:0] x_r    [STEPS+1];
  logic signed [CW-1:0] y_r    [STEPS+1];
  logic signed [CW-1:0] z_r    [STEPS+1];
  logic                 yz_r   [STEPS+1];
  logic                 xn_r   [STEPS+1];

  logic signed [CW-1:0] xi, yi, zsum;
  logic signed [16:0]   r17, rw;

  assign xi = CW'(in_side.item.pos_x);
  assign yi = CW'(in_side.item.pos_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int k = 0; k < STEPS; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    yz_r[0]   <= (yi == '0);
    xn_r[0]   <= xi[CW-1];
    // left half plane: turn by 180 degrees first
    if (xi[CW-1]) begin
      x_r[0] <= -xi;
      y_r[0] <= -yi;
      z_r[0] <= yi[CW-1] ? -lrotf_pkg::HALF_TURN_Q16 : lrotf_pkg::HALF_TURN_Q16;
    end else begin
      x_r[0] <= xi;
      y_r[0] <= yi;
      z_r[0] <= '0;
    end
    for (int k = 0; k < STEPS; k++) begin
      side_r[k+1] <= side_r[k];
      yz_r[k+1]   <= yz_r[k];
      xn_r[k+1]   <= xn_r[k];
      if (!y_r[k][CW-1]) begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + lrotf_pkg::atan_q16(k);
      end else begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - lrotf_pkg::atan_q16(k);
      end
    end
  end

  always_comb begin
    zsum = z_r[STEPS] + CW'(512);
    r17  = zsum[CW-1:10];
    if (r17 > lrotf_pkg::HALF_TURN_64)        rw = r17 - lrotf_pkg::FULL_TURN_64;
    else if (r17 <= -lrotf_pkg::HALF_TURN_64) rw = r17 + lrotf_pkg::FULL_TURN_64;
    else                                      rw = r17;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v_r[STEPS];
  end

  always_ff @(posedge clk) begin
    out_side <= side_r[STEPS];
    if (yz_r[STEPS]) out_yaw <= xn_r[STEPS] ? lrotf_pkg::YW'(lrotf_pkg::HALF_TURN_64) : '0;
    else             out_yaw <= rw[lrotf_pkg::YW-1:0];
  end

endmodule

// File: rtl/lrotf_back.sv
// Back end: time scaling, range test, CORDIC yaw, ring store and time-from-yaw pipeline.
module lrotf_back #(
  parameter int MAX_RINGS    = lrotf_pkg::MAX_RINGS_DEF,
  parameter int CORDIC_STEPS = lrotf_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  lrotf_pkg::item_t q_item,
  output logic             q_pop,
  input  logic [15:0]      blind_mm,
  input  logic [31:0]      time_scale,
  input  logic             out_take,
  output logic             o_push,
  output lrotf_pkg::res_t  o_res
);

  localparam int RW  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int CRW = $clog2(lrotf_pkg::OUT_DEPTH + 1);
  localparam int YW  = lrotf_pkg::YW;

  // credit: beats issued and not yet popped or dropped
  logic [CRW-1:0] credit_r, credit_nxt;
  logic           drop;

  // stage 1
  logic               v1_r;
  lrotf_pkg::item_t   it1_r;
  logic signed [64:0] prod_r;
  logic [47:0]        xx_r, yy_r, zz_r;
  logic [31:0]        bb_r;
  // stage 2
  logic               v2_r;
  lrotf_pkg::side_t   s2_r;
  logic signed [64:0] rnd, shd;
  logic [48:0]        r2;
  lrotf_pkg::side_t   s2_nxt;
  // cordic out
  logic               cv;
  lrotf_pkg::side_t   cside;
  logic signed [YW-1:0] cyaw;
  // stage A
  logic               va_r;
  lrotf_pkg::side_t   sa_r;
  logic signed [YW-1:0] ya_r;
  logic signed [YW-1:0] f_mem [MAX_RINGS];
  logic signed [YW-1:0] f_rd_r, f_cur;
  logic               fwf_v_r;
  logic [RW-1:0]      fwf_ring_r;
  logic signed [YW-1:0] fwf_val_r;
  logic [MAX_RINGS-1:0] unseen_r, unseen_nxt;
  logic [RW-1:0]      idx_c, idx_a, idx_b, idx_d;
  logic               az_a, uns_a, fwe;
  logic signed [16:0] diff, dfull;
  // stage B
  logic               vb_r, firstb_r;
  lrotf_pkg::side_t   sb_r;
  logic [14:0]        db_r;
  // stage C
  logic               vc_r, firstc_r;
  lrotf_pkg::side_t   sc_r;
  logic [26:0]        nc_r;
  // stage D
  logic               vd_r, firstd_r;
  lrotf_pkg::side_t   sd_r;
  logic [54:0]        pd_r;
  logic [19:0]        lt_mem [MAX_RINGS];
  logic [19:0]        lt_rd_r, lt_cur;
  logic               fwl_v_r;
  logic [RW-1:0]      fwl_ring_r;
  logic [19:0]        fwl_val_r;
  logic [17:0]        us, us2;
  logic               az_d, lwe, emit;
  logic [19:0]        lt_wval;

  assign q_pop = !q_empty && (credit_r < CRW'(lrotf_pkg::OUT_DEPTH));

  always_comb begin
    credit_nxt = credit_r + CRW'(q_pop) - CRW'(out_take) - CRW'(drop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) credit_r <= '0;
    else        credit_r <= credit_nxt;
  end

  // ---- stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= q_pop;
  end

  always_ff @(posedge clk) begin
    it1_r  <= q_item;
    prod_r <= 65'(q_item.raw_time) * 65'($signed({1'b0, time_scale}));
    xx_r   <= 48'(q_item.pos_x) * 48'(q_item.pos_x);
    yy_r   <= 48'(q_item.pos_y) * 48'(q_item.pos_y);
    zz_r   <= 48'(q_item.pos_z) * 48'(q_item.pos_z);
    bb_r   <= 32'(blind_mm) * 32'(blind_mm);
  end

  // ---- stage 2: round, saturate, range compare
  always_comb begin
    rnd = prod_r + 65'sd32768;
    shd = rnd >>> 16;
    r2  = {1'b0, xx_r} + {1'b0, yy_r} + {1'b0, zz_r};
    s2_nxt.item = it1_r;
    if (shd > 65'sd2147483647)       s2_nxt.t_given = 32'sh7fffffff;
    else if (shd < -65'sd2147483648) s2_nxt.t_given = 32'sh80000000;
    else                             s2_nxt.t_given = shd[31:0];
    s2_nxt.far = r2 > {17'b0, bb_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  lrotf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_side   (s2_r),
    .out_valid (cv),
    .out_side  (cside),
    .out_yaw   (cyaw)
  );

  // ---- stage A: first-yaw store and unseen flags
  assign idx_c = cside.item.ring[RW-1:0];
  assign idx_a = sa_r.item.ring[RW-1:0];

  always_comb begin
    az_a  = !sa_r.item.given && sa_r.item.in_use;
    uns_a = sa_r.item.frame_start || (az_a ? unseen_r[idx_a] : 1'b0);
    fwe   = va_r && az_a && uns_a;
    // read was issued while the previous beat was writing
    f_cur = (fwf_v_r && fwf_ring_r == idx_a) ? fwf_val_r : f_rd_r;
    diff  = 17'(f_cur) - 17'(ya_r);
    dfull = (ya_r <= f_cur) ? diff : diff + lrotf_pkg::FULL_TURN_64;
    unseen_nxt = unseen_r;
    if (va_r) begin
      if (sa_r.item.frame_start) unseen_nxt = '1;
      if (az_a) unseen_nxt[idx_a] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      unseen_r <= '1;
      fwf_v_r  <= 1'b0;
    end else begin
      va_r     <= cv;
      unseen_r <= unseen_nxt;
      fwf_v_r  <= fwe;
    end
  end

  always_ff @(posedge clk) begin
    sa_r       <= cside;
    ya_r       <= cyaw;
    f_rd_r     <= f_mem[idx_c];
    fwf_ring_r <= idx_a;
    fwf_val_r  <= ya_r;
    if (fwe) f_mem[idx_a] <= ya_r;
  end

  // ---- stage B: numerator
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    sb_r     <= sa_r;
    firstb_r <= uns_a;
    db_r     <= dfull[14:0];
  end

  // stage C: scale and round
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    sc_r     <= sb_r;
    firstc_r <= firstb_r;
    nc_r     <= 27'(db_r) * 27'(lrotf_pkg::DIST_MUL) + lrotf_pkg::DIST_ROUND;
  end

  assign idx_b = sc_r.item.ring[RW-1:0];
  assign idx_d = sd_r.item.ring[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    sd_r     <= sc_r;
    firstd_r <= firstc_r;
    pd_r     <= 55'(nc_r) * 55'(lrotf_pkg::DIST_RECIP);
    lt_rd_r  <= lt_mem[idx_b];
  end

  // ---- stage D: last-time store, revolution fix, emit
  always_comb begin
    us     = pd_r[54:lrotf_pkg::DIST_SHIFT];
    lt_cur = (fwl_v_r && fwl_ring_r == idx_d) ? fwl_val_r : lt_rd_r;
    us2    = ({2'b0, us} < lt_cur) ? us + lrotf_pkg::REV_US : us;
    az_d   = !sd_r.item.given && sd_r.item.in_use;
    lwe    = vd_r && az_d;
    lt_wval = firstd_r ? 20'd0 : {2'b0, us2};
    emit   = vd_r && sd_r.item.in_use && sd_r.item.phase_ok && sd_r.far &&
             (sd_r.item.given || !firstd_r);
    drop   = vd_r && !emit;
    o_push = emit;
    o_res.x        = sd_r.item.pos_x;
    o_res.y        = sd_r.item.pos_y;
    o_res.z        = sd_r.item.pos_z;
    o_res.strength = sd_r.item.strength;
    o_res.time_us  = sd_r.item.given ? sd_r.t_given : $signed({14'b0, us2});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fwl_v_r <= 1'b0;
    else        fwl_v_r <= lwe;
  end

  always_ff @(posedge clk) begin
    fwl_ring_r <= idx_d;
    fwl_val_r  <= lt_wval;
    if (lwe) lt_mem[idx_d] <= lt_wval;
  end

endmodule

// File: rtl/lidar_ring_offset_time_filter.sv
// Top level of the lidar ring offset time filter.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  in       | push / full        | frame_start times_given pos_x/y/z strength ring raw_time
//  out      | empty / pop        | out_x/y/z out_strength out_offset_time_us
//  cfg      | cfg_we (no wait)   | cfg_index cfg_data
//
// One point per cycle sustained while full is low; the path from push to a visible
// result runs through the CORDIC pipeline and the reciprocal-multiply stages.
// Synchronous active-low reset clears the queues and the frame phase and sets the unseen
// flags; no clearing pass is needed. full rises only when the classify queue
// backs up behind a stalled result side.
module lidar_ring_offset_time_filter #(
  parameter int MAX_RINGS    = lrotf_pkg::MAX_RINGS_DEF,
  parameter int CORDIC_STEPS = lrotf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_frame_start,
  input  logic               in_times_given,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_strength,
  input  logic [7:0]         in_ring,
  input  logic signed [31:0] in_raw_time,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic [15:0]        out_strength,
  output logic signed [31:0] out_offset_time_us,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IW = $bits(lrotf_pkg::item_t);
  localparam int OW = $bits(lrotf_pkg::res_t);

  logic [7:0]  ring_count_r;
  logic [6:0]  decimation_r;
  logic [15:0] blind_mm_r;
  logic [31:0] time_scale_r;

  logic             fq_push, fq_full, fq_empty, fq_pop;
  lrotf_pkg::item_t fq_in, fq_out;
  logic             o_push, o_full;
  lrotf_pkg::res_t  o_res, o_head;
  logic             out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= 8'd16;
      decimation_r <= 7'd1;
      blind_mm_r   <= 16'd1000;
      time_scale_r <= 32'd65536;
    end else if (cfg_we) begin
      case (lrotf_pkg::cfg_reg_t'(cfg_index))
        lrotf_pkg::CFG_RING_COUNT: ring_count_r <= cfg_data[7:0];
        lrotf_pkg::CFG_DECIMATION: decimation_r <= cfg_data[6:0];
        lrotf_pkg::CFG_BLIND_MM:   blind_mm_r   <= cfg_data[15:0];
        lrotf_pkg::CFG_TIME_SCALE: time_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lrotf_front #(
    .MAX_RINGS (MAX_RINGS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .frame_start (in_frame_start),
    .times_given (in_times_given),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pos_z       (in_pos_z),
    .strength    (in_strength),
    .ring        (in_ring),
    .raw_time    (in_raw_time),
    .ring_count  (ring_count_r),
    .decimation  (decimation_r),
    .q_full      (fq_full),
    .q_push      (fq_push),
    .q_item      (fq_in)
  );

  assign full = fq_full;

  lrotf_fifo #(
    .WIDTH (IW),
    .DEPTH (lrotf_pkg::Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_in),
    .pop   (fq_pop),
    .dout  (fq_out),
    .full  (fq_full),
    .empty (fq_empty)
  );

  lrotf_back #(
    .MAX_RINGS    (MAX_RINGS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (fq_empty),
    .q_item     (fq_out),
    .q_pop      (fq_pop),
    .blind_mm   (blind_mm_r),
    .time_scale (time_scale_r),
    .out_take   (out_take),
    .o_push     (o_push),
    .o_res      (o_res)
  );

  assign out_take = pop && !empty;

  // credit in the back end keeps this from ever overflowing
  lrotf_fifo #(
    .WIDTH (OW),
    .DEPTH (lrotf_pkg::OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_res),
    .pop   (out_take),
    .dout  (o_head),
    .full  (o_full),
    .empty (empty)
  );

  assign out_x              = o_head.x;
  assign out_y              = o_head.y;
  assign out_z              = o_head.z;
  assign out_strength       = o_head.strength;
  assign out_offset_time_us = (o_full && empty) ? '0 : o_head.time_us;

endmodule

// File: rtl/lrotf_checker.sv
// Port-level checks for the lidar ring offset time filter, bound to the top level.
module lrotf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [23:0] out_x,
  input logic signed [31:0] out_offset_time_us
);

  // reset leaves both queues empty
  a_reset_state: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // nothing can show right after reset: a result must pass the whole pipeline first
  a_no_early_result: assert property (@(posedge clk) $rose(rst_n) |-> ##2 empty)
    else $error("result appeared too soon after reset");

  // classify queue cannot fill right after reset
  a_no_early_full: assert property (@(posedge clk) $rose(rst_n) |-> !full ##1 !full ##1 !full)
    else $error("input side full too soon after reset");

  // a waiting result holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_x) && $stable(out_offset_time_us))
    else $error("waiting result changed");

endmodule

bind lidar_ring_offset_time_filter lrotf_checker u_chk (.*);

// File: tb/testbench.sv
// Testbench for the lidar ring offset time filter: queue-fed driver, monitor and predictor.
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 40;

  typedef struct {
    bit               frame_start;
    bit               times_given;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]      strength;
    logic [7:0]       ring;
    logic signed [31:0] raw_time;
  } point_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        strength;
    logic signed [31:0] time_us;
  } kept_t;

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic full;
  logic in_frame_start = 0;
  logic in_times_given = 0;
  logic signed [23:0] in_pos_x = 0;
  logic signed [23:0] in_pos_y = 0;
  logic signed [23:0] in_pos_z = 0;
  logic [15:0] in_strength = 0;
  logic [7:0] in_ring = 0;
  logic signed [31:0] in_raw_time = 0;
  logic empty;
  logic pop = 0;
  logic signed [23:0] out_x, out_y, out_z;
  logic [15:0] out_strength;
  logic signed [31:0] out_offset_time_us;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  point_t pending_points[$];
  kept_t  kept_points[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     gap = 0;
  int     stall = 0;
  bit     in_taken = 0;

  // predictor state
  logic [7:0]  p_ring_count;
  logic [6:0]  p_decimation;
  logic [15:0] p_blind_mm;
  logic [31:0] p_time_scale;
  bit          unseen[128];
  int          first_yaw[128];
  int unsigned last_us[128];
  int unsigned phase;

  lidar_ring_offset_time_filter DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int short_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return tbl[i];
  endfunction

  function automatic int yaw_of(longint x, longint y);
    longint z, t;
    int r;
    z = 0;
    if (y == 0) return (x < 0) ? 11520 : 0;
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step(i);
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step(i);
      end
      x = t;
    end
    r = int'((z + 512) >>> 10);
    while (r > 11520) r -= 23040;
    while (r <= -11520) r += 23040;
    return r;
  endfunction

  task automatic predict_point(point_t p);
    int unsigned dec, lim, us;
    bit phase_ok, keep;
    longint t, prod, x, y, z;
    longint unsigned r2, b2;
    int yaw, f, d;
    kept_t k;
    dec = (p_decimation == 0) ? 1 : ((p_decimation > 64) ? 64 : p_decimation);
    lim = (p_ring_count < 128) ? p_ring_count : 128;
    keep = 1;
    t = 0;
    x = p.x;
    y = p.y;
    z = p.z;
    if (p.frame_start) begin
      foreach (unseen[i]) unseen[i] = 1;
      phase = 0;
    end
    phase_ok = (phase == 0);
    phase = (phase + 1 >= dec) ? 0 : ((phase + 1) & 63);
    if (p.ring >= lim) return;
    if (p.times_given) begin
      prod = longint'(p.raw_time) * longint'({32'd0, p_time_scale});
      t = (prod + 32768) >>> 16;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
    end else begin
      yaw = yaw_of(x, y);
      if (unseen[p.ring]) begin
        unseen[p.ring] = 0;
        first_yaw[p.ring] = yaw;
        last_us[p.ring] = 0;
        keep = 0;
      end else begin
        f = first_yaw[p.ring];
        d = (yaw <= f) ? (f - yaw) : (f - yaw + 23040);
        us = int'((longint'(d) * 100000 + 11552) / 23104);
        if (us < last_us[p.ring]) us += 99723;
        last_us[p.ring] = us & 32'hFFFFF;
        t = us;
      end
    end
    if (!keep || !phase_ok) return;
    r2 = x * x + y * y + z * z;
    b2 = longint'(p_blind_mm) * longint'(p_blind_mm);
    if (!(r2 > b2)) return;
    k.x = p.x;
    k.y = p.y;
    k.z = p.z;
    k.strength = p.strength;
    k.time_us = t[31:0];
    kept_points = {kept_points, k};
  endtask

  // driver: a new beat goes out only after the previous one was taken at the rising edge and any random gap ran out
  always @(negedge clk) begin
    if (!push || in_taken) begin
      if (gap > 0) begin
        gap--;
        push <= 0;
      end else if (pending_points.size() > 0 && rst_n) begin
        point_t p;
        p = pending_points.pop_front();
        predict_point(p);
        push <= 1;
        in_frame_start <= p.frame_start;
        in_times_given <= p.times_given;
        in_pos_x <= p.x;
        in_pos_y <= p.y;
        in_pos_z <= p.z;
        in_strength <= p.strength;
        in_ring <= p.ring;
        in_raw_time <= p.raw_time;
        gap = short_gap();
      end else begin
        push <= 0;
      end
    end
    if (stall > 0) begin
      stall--;
      pop <= 0;
    end else begin
      pop <= 1;
      stall = short_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken = rst_n && push && !full;
    if (rst_n) begin
      idle_cycles++;
      if (push && !full) idle_cycles = 0;
      if (pop && !empty) begin
        idle_cycles = 0;
        if (kept_points.size() == 0) begin
          $display("%0t: unexpected beat x=%0d y=%0d", $time, out_x, out_y);
          errors++;
        end else begin
          kept_t e;
          e = kept_points.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
              out_strength !== e.strength || out_offset_time_us !== e.time_us) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d s=%0d t=%0d",
                     $time, e.x, e.y, e.z, e.strength, e.time_us);
            $display("%0t:          actual   x=%0d y=%0d z=%0d s=%0d t=%0d",
                     $time, out_x, out_y, out_z, out_strength, out_offset_time_us);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 60000)) - 30000);
    endcase
  endfunction

  function automatic point_t make_point(bit fs, bit tg, int ring_hi);
    point_t p;
    p.frame_start = fs;
    p.times_given = tg;
    p.x = rand_coord();
    p.y = ($urandom_range(0, 15) == 0) ? 24'sd0 : rand_coord();
    p.z = rand_coord();
    p.strength = 16'($urandom);
    p.ring = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, ring_hi));
    p.raw_time = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'sh7FFFFFFF
                 : -32'sh80000000) : 32'($urandom);
    return p;
  endfunction

  task automatic write_reg(lrotf_pkg::cfg_reg_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      lrotf_pkg::CFG_RING_COUNT: p_ring_count = v[7:0];
      lrotf_pkg::CFG_DECIMATION: p_decimation = v[6:0];
      lrotf_pkg::CFG_BLIND_MM:   p_blind_mm = v[15:0];
      lrotf_pkg::CFG_TIME_SCALE: p_time_scale = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || kept_points.size() > 0 || push) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    point_t p;
    p_ring_count = 16;
    p_decimation = 1;
    p_blind_mm = 1000;
    p_time_scale = 65536;
    foreach (unseen[i]) unseen[i] = 1;
    phase = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: rotate through quadrants on one ring, zero-y, far/near, given times
    write_reg(lrotf_pkg::CFG_BLIND_MM, 0);
    for (int i = 0; i < 20; i++) begin
      p = make_point(i == 0, i >= 14, 3);
      p.ring = (i < 12) ? 1 : i[7:0];
      case (i % 4)
        0: begin p.x = 24'sd5000;  p.y = 24'sd0; end
        1: begin p.x = -24'sd5000; p.y = 24'sd0; end
        2: begin p.x = -24'sd3000; p.y = -24'sd4000; end
        3: begin p.x = 24'sd3000;  p.y = 24'sd4000; end
        default: ;
      endcase
      if (i == 7) begin p.x = 0; p.y = 0; p.z = 0; end
      pending_points = {pending_points, p};
    end
    drain();

    for (int phz = 0; phz < 6; phz++) begin
      case (phz)
        0: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 16);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 1);
                 write_reg(lrotf_pkg::CFG_BLIND_MM, 1000);
                 write_reg(lrotf_pkg::CFG_TIME_SCALE, 65536); end
        1: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 128);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 64);
                 write_reg(lrotf_pkg::CFG_TIME_SCALE, 32'hFFFFFFFF); end
        2: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 1);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 0);
                 write_reg(lrotf_pkg::CFG_BLIND_MM, 65535);
                 write_reg(lrotf_pkg::CFG_TIME_SCALE, 0); end
        3: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 255);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 127);
                 write_reg(lrotf_pkg::CFG_BLIND_MM, 0);
                 write_reg(lrotf_pkg::CFG_TIME_SCALE, $urandom); end
        4: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 8);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 3);
                 write_reg(lrotf_pkg::CFG_BLIND_MM, 500); end
        5: begin write_reg(lrotf_pkg::CFG_RING_COUNT, 32);
                 write_reg(lrotf_pkg::CFG_DECIMATION, 2);
                 write_reg(lrotf_pkg::CFG_TIME_SCALE, 65536); end
        default: ;
      endcase
      for (int i = 0; i < 190; i++) begin
        bit fs;
        fs = (i == 0) || ($urandom_range(0, 49) == 0);
        p = make_point(fs, $urandom_range(0, 3) == 0,
                       (p_ring_count > 1) ? p_ring_count - 1 : 0);
        pending_points = {pending_points, p};
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
